// ----- rtl/utf8v_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types, constants and helpers of the UTF-8 stream validator
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned REM_W  = 2;
    localparam int unsigned ERR_W  = 3;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 3'd4;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_STRAY    = 3'd1,
        ERR_LEAD     = 3'd2,
        ERR_MISSING  = 3'd3,
        ERR_TRUNC    = 3'd4,
        ERR_OVERLONG = 3'd5,
        ERR_RANGE    = 3'd6
    } t_err;

    typedef struct packed {
        logic [REM_W-1:0] bytes_remaining;
        logic [LEN_W-1:0] sequence_length;
        logic [CP_W-1:0]  partial_code_point;
        t_err             first_error;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        bytes_remaining:    '0,
        sequence_length:    '0,
        partial_code_point: '0,
        first_error:        ERR_NONE
    };

    typedef struct packed {
        logic is_valid;
        t_err error_kind;
    } t_result;

    // clamp a written maximum to 1..4
    function automatic logic [LEN_W-1:0] clamp_max_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == 3'd0) begin
            r = 3'd1;
        end else if (v > 3'd4) begin
            r = 3'd4;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // sequence length 2..6 from a lead byte pattern, 0 for any other byte
    function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] n;
        if (b[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            n = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            n = 3'd4;
        end else if (b[7:2] == 6'b111110) begin
            n = 3'd5;
        end else if (b[7:1] == 7'b1111110) begin
            n = 3'd6;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

    function automatic logic [CP_W-1:0] min_for_length(input logic [LEN_W-1:0] l);
        logic [CP_W-1:0] r;
        case (l)
            3'd2:    r = 21'h000080;
            3'd3:    r = 21'h000800;
            3'd4:    r = 21'h010000;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [CP_W-1:0] max_for_length(input logic [LEN_W-1:0] l);
        logic [CP_W-1:0] r;
        case (l)
            3'd2:    r = 21'h0007FF;
            3'd3:    r = 21'h00FFFF;
            3'd4:    r = 21'h10FFFF;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/utf8v_step.sv -----
// ----------------------------------------------------------------------------
// utf8v_step
// Per-byte decode: next message state and the verdict for a terminator
// ----------------------------------------------------------------------------
module utf8v_step (
    input  utf8v_pkg::t_state                  i_state,
    input  logic [utf8v_pkg::BYTE_W-1:0]       i_text_byte,
    input  logic [utf8v_pkg::LEN_W-1:0]        i_max_len,
    output utf8v_pkg::t_state                  o_state,
    output logic                               o_is_term,
    output utf8v_pkg::t_result                 o_result
);

    logic [utf8v_pkg::LEN_W-1:0] len;
    logic [utf8v_pkg::CP_W-1:0]  cp_shift;
    logic                        is_cont;
    utf8v_pkg::t_err             term_err;

    always_comb begin
        len      = utf8v_pkg::lead_length(i_text_byte);
        cp_shift = {i_state.partial_code_point[utf8v_pkg::CP_W-7:0], i_text_byte[5:0]};
        is_cont  = (i_text_byte[7:6] == 2'b10);
        o_is_term = (i_text_byte == '0);

        term_err = i_state.first_error;
        if (term_err == utf8v_pkg::ERR_NONE && i_state.bytes_remaining != '0) begin
            term_err = utf8v_pkg::ERR_TRUNC;
        end
        o_result.is_valid   = (term_err == utf8v_pkg::ERR_NONE);
        o_result.error_kind = term_err;

        o_state = i_state;
        if (o_is_term) begin
            o_state = utf8v_pkg::STATE_CLEAR;
        end else if (i_state.first_error != utf8v_pkg::ERR_NONE) begin
            o_state = i_state;
        end else if (i_state.bytes_remaining != '0) begin
            if (!is_cont) begin
                o_state.first_error = utf8v_pkg::ERR_MISSING;
            end else if (i_state.bytes_remaining == 2'd1) begin
                if (cp_shift < utf8v_pkg::min_for_length(i_state.sequence_length)) begin
                    o_state.first_error = utf8v_pkg::ERR_OVERLONG;
                end else if (cp_shift >
                             utf8v_pkg::max_for_length(i_state.sequence_length)) begin
                    o_state.first_error = utf8v_pkg::ERR_RANGE;
                end
                o_state.bytes_remaining    = '0;
                o_state.sequence_length    = '0;
                o_state.partial_code_point = '0;
            end else begin
                o_state.bytes_remaining    = i_state.bytes_remaining - 2'd1;
                o_state.partial_code_point = cp_shift;
            end
        end else if (!i_text_byte[7]) begin
            o_state = i_state;
        end else if (is_cont) begin
            o_state.first_error = utf8v_pkg::ERR_STRAY;
        end else if (len < 3'd2 || len > i_max_len || len > 3'd4) begin
            o_state.first_error = utf8v_pkg::ERR_LEAD;
        end else begin
            o_state.sequence_length = len;
            o_state.bytes_remaining = 2'(len - 3'd1);
            case (len)
                3'd2:    o_state.partial_code_point = {16'd0, i_text_byte[4:0]};
                3'd3:    o_state.partial_code_point = {17'd0, i_text_byte[3:0]};
                default: o_state.partial_code_point = {18'd0, i_text_byte[2:0]};
            endcase
        end
    end

endmodule

// ----- rtl/utf8_stream_validator_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator_unit
// Checks a byte stream for well-formed UTF-8, one zero-terminated message
// at a time
// ----------------------------------------------------------------------------
// Input channel: one text byte per item on i_in_valid / o_in_stall; a zero
// byte ends the message. Output channel: one verdict item per message on
// o_out_valid / i_out_stall, carrying o_is_valid and o_error_kind; no other
// byte produces an item.
// Configuration: i_cfg_wr_en with i_cfg_wr_data writes the maximum sequence
// length, clamped to 1..4, reset value 4; write only while the block is idle.
// Throughput is one byte per cycle while no terminator is held back by a
// stalled verdict; each byte waits in the input register while the decode
// logic updates the message state. An accepted terminator passes through the
// input register and then the output register before its verdict shows.
// A stalled verdict holds in the output register; bytes that are not
// terminators keep flowing, and a following terminator waits in the input
// register, raising o_in_stall, until the verdict is taken.
// Reset clears the message state, both valid flags and restores the maximum.
// ----------------------------------------------------------------------------
module utf8_stream_validator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [utf8v_pkg::BYTE_W-1:0]  i_text_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_is_valid,
    output logic [utf8v_pkg::ERR_W-1:0]   o_error_kind,
    input  logic                          i_cfg_wr_en,
    input  logic [utf8v_pkg::LEN_W-1:0]   i_cfg_wr_data
);

    logic                          r_in_valid;
    logic [utf8v_pkg::BYTE_W-1:0]  r_in_byte;
    utf8v_pkg::t_state             r_state;
    utf8v_pkg::t_state             n_state;
    logic [utf8v_pkg::LEN_W-1:0]   r_max_len;
    logic                          r_out_valid;
    utf8v_pkg::t_result            r_result;
    utf8v_pkg::t_result            n_result;

    logic is_term;
    logic out_free;
    logic advance;
    logic in_take;

    utf8v_step u_step (
        .i_state     (r_state),
        .i_text_byte (r_in_byte),
        .i_max_len   (r_max_len),
        .o_state     (n_state),
        .o_is_term   (is_term),
        .o_result    (n_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!is_term || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= utf8v_pkg::STATE_CLEAR;
            r_max_len   <= utf8v_pkg::MAX_LEN_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && is_term) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_max_len <= utf8v_pkg::clamp_max_len(i_cfg_wr_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_text_byte;
        end
        if (advance && is_term) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_valid   = r_result.is_valid;
    assign o_error_kind = r_result.error_kind;

endmodule
